/* src/tgr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tgr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int TIME_BITS_DEF = 32;
	localparam int PTR_W = 20;
	localparam int RES_W = 14;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [12:0] SCREEN_W_RST = 13'd1920;
	localparam logic [12:0] SCREEN_H_RST = 13'd1080;
	localparam logic [15:0] TAP_TIME_RST = 16'd180;
	localparam logic [7:0] TAP_RADIUS_RST = 8'd10;
	localparam logic [15:0] HOLD_TIME_RST = 16'd400;
	localparam logic [7:0] SCROLL_STEP_RST = 8'd40;
	localparam logic [9:0] SPEED_RST = 10'd307;

	typedef enum logic [2:0] {
		CFG_SCREEN_W = 3'd0,
		CFG_SCREEN_H = 3'd1,
		CFG_TAP_TIME = 3'd2,
		CFG_TAP_RADIUS = 3'd3,
		CFG_HOLD_TIME = 3'd4,
		CFG_SCROLL_STEP = 3'd5,
		CFG_SPEED = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_DOWN = 2'd0,
		ACT_MOVE = 2'd1,
		ACT_UP = 2'd2,
		ACT_TICK = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		K_MOVE = 3'd0,
		K_PRESS = 3'd1,
		K_RELEASE = 3'd2,
		K_CLICK = 3'd3,
		K_SCROLL = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		G_IDLE = 3'd0,
		G_TRACKING = 3'd1,
		G_MOVING = 3'd2,
		G_DRAGGING = 3'd3,
		G_TWO = 3'd4
	} gesture_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_EVAL,
		ST_DIV,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic commit;
		logic div_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic emit;
		logic div_done;
		logic fin_emit;
	} sts_t;

endpackage
`default_nettype wire

/* src/tgr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module tgr_ctrl
	import tgr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;
	logic emit_now;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CALC;
			ST_CALC: state_d = ST_EVAL;
			ST_EVAL: begin
				if (out_free) state_d = sts.need_div ? ST_DIV : ST_IDLE;
			end
			ST_DIV: if (sts.div_done) state_d = ST_FIN;
			ST_FIN: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		emit_now = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_CALC: cmd.calc = 1'b1;
			ST_EVAL: begin
				cmd.commit = out_free;
				emit_now = out_free && sts.emit;
			end
			ST_DIV: cmd.div_step = !sts.div_done;
			ST_FIN: begin
				cmd.fin = out_free;
				emit_now = out_free && sts.fin_emit;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_now) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* src/tgr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module tgr_datapath
	import tgr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output sts_t sts,
	input wire logic [1:0] action,
	input wire logic [3:0] slot,
	input wire logic [COORD_BITS-1:0] touch_x,
	input wire logic [COORD_BITS-1:0] touch_y,
	input wire logic [TIME_BITS-1:0] stamp_ms,
	input wire logic [15:0] elapsed_ms,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic [2:0] kind,
	output logic button,
	output logic [11:0] cursor_x,
	output logic [11:0] cursor_y,
	output logic signed [13:0] scroll_ticks
);

	localparam int CW = COORD_BITS;
	localparam int SQW = 2 * CW + 2;
	localparam int MW = CW + 12;
	localparam int SW = ((MW > PTR_W + 1) ? MW : PTR_W + 1) + 1;
	localparam int AW = CW + 3;
	localparam int CNT_W = $clog2(AW + 1);

	logic [12:0] scr_w_q, scr_h_q;
	logic [15:0] tap_time_q, hold_time_q;
	logic [7:0] tap_rad_q, step_q;
	logic [9:0] speed_q;

	logic [1:0] act_q;
	logic [3:0] slot_q;
	logic [CW-1:0] x_q, y_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [15:0] el_q;

	gesture_t gest_q;
	logic [CW-1:0] fdx_q, fdy_q, flx_q, fly_q, sly_q;
	logic [TIME_BITS-1:0] fdt_q;
	logic sec_q;
	logic signed [RES_W-1:0] res_q;
	logic [15:0] hold_q;
	logic [PTR_W-1:0] px_q, py_q;

	logic [SQW-1:0] sqx_s1, sqy_s1;
	logic signed [MW-1:0] mulx_s1, muly_s1;
	logic signed [AW-1:0] acc_s1;
	logic quick_s1;
	logic [15:0] rsq_s1;

	logic [AW-1:0] quo_q;
	logic [7:0] rem_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;

	kind_t kind_q;
	logic button_q;
	logic [11:0] cx_q, cy_q;
	logic signed [13:0] ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SCREEN_W_RST;
			scr_h_q <= SCREEN_H_RST;
			tap_time_q <= TAP_TIME_RST;
			tap_rad_q <= TAP_RADIUS_RST;
			hold_time_q <= HOLD_TIME_RST;
			step_q <= SCROLL_STEP_RST;
			speed_q <= SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_W: scr_w_q <= cfg_data[12:0];
				CFG_SCREEN_H: scr_h_q <= cfg_data[12:0];
				CFG_TAP_TIME: tap_time_q <= cfg_data;
				CFG_TAP_RADIUS: tap_rad_q <= cfg_data[7:0];
				CFG_HOLD_TIME: hold_time_q <= cfg_data;
				CFG_SCROLL_STEP: step_q <= cfg_data[7:0];
				CFG_SPEED: speed_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			slot_q <= slot;
			x_q <= touch_x;
			y_q <= touch_y;
			stamp_q <= stamp_ms;
			el_q <= elapsed_ms;
		end
	end

	logic [CW-1:0] bx, by;
	logic signed [CW:0] ddx, ddy, mdx, mdy;
	logic signed [SQW-1:0] sqx_c, sqy_c;
	logic [TIME_BITS-1:0] dt;

	always_comb begin
		bx = (act_q == ACT_TICK) ? flx_q : x_q;
		by = (act_q == ACT_TICK) ? fly_q : y_q;
		ddx = $signed({1'b0, fdx_q}) - $signed({1'b0, bx});
		ddy = $signed({1'b0, fdy_q}) - $signed({1'b0, by});
		mdx = $signed({1'b0, x_q}) - $signed({1'b0, flx_q});
		mdy = $signed({1'b0, y_q}) - $signed({1'b0, fly_q});
		sqx_c = SQW'(ddx * ddx);
		sqy_c = SQW'(ddy * ddy);
		dt = stamp_q - fdt_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			sqx_s1 <= $unsigned(sqx_c);
			sqy_s1 <= $unsigned(sqy_c);
			mulx_s1 <= MW'(mdx * $signed({1'b0, speed_q}));
			muly_s1 <= MW'(mdy * $signed({1'b0, speed_q}));
			acc_s1 <= AW'(res_q) + AW'($signed({1'b0, y_q})) - AW'($signed({1'b0, sly_q}));
			quick_s1 <= dt <= TIME_BITS'(tap_time_q);
			rsq_s1 <= tap_rad_q * tap_rad_q;
		end
	end

	function automatic logic [PTR_W-1:0] limit_of(input logic [12:0] size);
		logic [12:0] s;
		s = size;
		if (s == 13'd0) s = 13'd1;
		if (s > 13'd4096) s = 13'd4096;
		limit_of = PTR_W'({s - 13'd1, 8'd0});
	endfunction

	function automatic logic [PTR_W-1:0] move_ptr(input logic [PTR_W-1:0] p,
			input logic signed [MW-1:0] d, input logic [PTR_W-1:0] lim);
		logic signed [SW-1:0] v;
		v = SW'($signed({1'b0, p})) + SW'(d);
		if (v < 0) move_ptr = '0;
		else if (v > SW'($signed({1'b0, lim}))) move_ptr = lim;
		else move_ptr = v[PTR_W-1:0];
	endfunction

	logic [SQW:0] dsum;
	logic near;
	logic [16:0] hsum;
	logic [15:0] hsat;
	logic [PTR_W-1:0] nx, ny;
	logic [RES_W-1:0] res_mag;
	logic emit_c;
	kind_t ekind;
	logic ebutton;
	logic is_s0, is_s1;

	always_comb begin
		dsum = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		near = dsum <= (SQW + 1)'(rsq_s1);
		hsum = {1'b0, hold_q} + {1'b0, el_q};
		hsat = hsum[16] ? 16'hFFFF : hsum[15:0];
		nx = move_ptr(px_q, mulx_s1, limit_of(scr_w_q));
		ny = move_ptr(py_q, muly_s1, limit_of(scr_h_q));
		res_mag = res_q[RES_W-1] ? $unsigned(-res_q) : $unsigned(res_q);
		is_s0 = slot_q == 4'd0;
		is_s1 = slot_q == 4'd1;
		emit_c = 1'b0;
		ekind = K_MOVE;
		ebutton = 1'b0;
		unique case (act_q)
			ACT_TICK: begin
				if (gest_q == G_TRACKING && near && hsat >= hold_time_q) begin
					emit_c = 1'b1;
					ekind = K_PRESS;
				end
			end
			ACT_MOVE: begin
				if (is_s0 && (gest_q == G_MOVING || gest_q == G_DRAGGING ||
						(gest_q == G_TRACKING && !near))) begin
					emit_c = 1'b1;
					ekind = K_MOVE;
				end
			end
			ACT_UP: begin
				if (is_s0) begin
					if (gest_q == G_TRACKING && quick_s1 && near) begin
						emit_c = 1'b1;
						ekind = K_CLICK;
					end else if (gest_q == G_DRAGGING) begin
						emit_c = 1'b1;
						ekind = K_RELEASE;
					end
				end else if (is_s1 && gest_q == G_TWO && quick_s1 &&
						res_mag < RES_W'(tap_rad_q)) begin
					emit_c = 1'b1;
					ekind = K_CLICK;
					ebutton = 1'b1;
				end
			end
			default: emit_c = 1'b0;
		endcase
	end

	assign sts.emit = emit_c;
	assign sts.need_div = act_q == ACT_MOVE && is_s1 && gest_q == G_TWO;
	assign sts.div_done = cnt_q == '0;
	assign sts.fin_emit = quo_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gest_q <= G_IDLE;
			fdx_q <= '0;
			fdy_q <= '0;
			fdt_q <= '0;
			flx_q <= '0;
			fly_q <= '0;
			sly_q <= '0;
			sec_q <= 1'b0;
			res_q <= '0;
			hold_q <= '0;
			px_q <= '0;
			py_q <= '0;
		end else if (cmd.commit) begin
			unique case (act_q)
				ACT_TICK: begin
					if (gest_q == G_TRACKING && near) begin
						if (hsat >= hold_time_q) begin
							gest_q <= G_DRAGGING;
							hold_q <= '0;
						end else begin
							hold_q <= hsat;
						end
					end else begin
						hold_q <= '0;
					end
				end
				ACT_DOWN: begin
					if (is_s0) begin
						fdx_q <= x_q;
						flx_q <= x_q;
						fdy_q <= y_q;
						fly_q <= y_q;
						fdt_q <= stamp_q;
						res_q <= '0;
						if (gest_q == G_IDLE) gest_q <= G_TRACKING;
					end else if (is_s1) begin
						sec_q <= 1'b1;
						sly_q <= y_q;
						res_q <= '0;
						gest_q <= G_TWO;
					end
				end
				ACT_MOVE: begin
					if (is_s0) begin
						if (emit_c) begin
							px_q <= nx;
							py_q <= ny;
							if (gest_q == G_TRACKING) gest_q <= G_MOVING;
						end
						flx_q <= x_q;
						fly_q <= y_q;
					end else if (is_s1) begin
						sly_q <= y_q;
					end
				end
				ACT_UP: begin
					if (is_s0) begin
						if (!sec_q) gest_q <= G_IDLE;
					end else if (is_s1) begin
						sec_q <= 1'b0;
						gest_q <= G_TRACKING;
					end
				end
				default: ;
			endcase
		end else if (cmd.fin) begin
			res_q <= neg_q ? -RES_W'($signed({1'b0, rem_q})) : RES_W'($signed({1'b0, rem_q}));
		end
	end

	logic [8:0] rsh;
	logic [7:0] divisor;
	logic take;

	always_comb begin
		divisor = (step_q == 8'd0) ? 8'd1 : step_q;
		rsh = {rem_q, quo_q[AW-1]};
		take = rsh >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.commit && sts.need_div) begin
			cnt_q <= CNT_W'(AW);
		end else if (cmd.div_step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && sts.need_div) begin
			neg_q <= acc_s1[AW-1];
			quo_q <= acc_s1[AW-1] ? $unsigned(-acc_s1) : $unsigned(acc_s1);
			rem_q <= '0;
		end else if (cmd.div_step && cnt_q != '0) begin
			rem_q <= take ? 8'(rsh - {1'b0, divisor}) : rsh[7:0];
			quo_q <= {quo_q[AW-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && emit_c) begin
			kind_q <= ekind;
			button_q <= ebutton;
			cx_q <= (ekind == K_MOVE) ? nx[PTR_W-1:8] : px_q[PTR_W-1:8];
			cy_q <= (ekind == K_MOVE) ? ny[PTR_W-1:8] : py_q[PTR_W-1:8];
			ticks_q <= '0;
		end else if (cmd.fin && sts.fin_emit) begin
			kind_q <= K_SCROLL;
			button_q <= 1'b0;
			cx_q <= px_q[PTR_W-1:8];
			cy_q <= py_q[PTR_W-1:8];
			ticks_q <= neg_q ? $signed(quo_q[13:0]) : -$signed(quo_q[13:0]);
		end
	end

	assign kind = kind_q;
	assign button = button_q;
	assign cursor_x = cx_q;
	assign cursor_y = cy_q;
	assign scroll_ticks = ticks_q;

endmodule
`default_nettype wire

/* src/trackpad_gesture_recognizer.sv */
// ST_IDLE takes a transaction, ST_CALC registers its squares and products and ST_EVAL
// commits it and registers its result; a second-finger move then goes through ST_DIV,
// the one-bit-a-cycle scroll divider, then ST_FIN. Each transaction is worked on alone;
// a new one is taken while the previous result still waits on the output.
// Reset: arst_n clears the gesture state, cursor and controller at once and loads the
// register defaults; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module trackpad_gesture_recognizer
	import tgr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] action,
	input wire logic [3:0] slot,
	input wire logic [COORD_BITS-1:0] touch_x,
	input wire logic [COORD_BITS-1:0] touch_y,
	input wire logic [TIME_BITS-1:0] stamp_ms,
	input wire logic [15:0] elapsed_ms,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] kind,
	output logic button,
	output logic [11:0] cursor_x,
	output logic [11:0] cursor_y,
	output logic signed [13:0] scroll_ticks,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tgr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts(sts),
		.cmd(cmd)
	);

	tgr_datapath #(
		.COORD_BITS(COORD_BITS),
		.TIME_BITS(TIME_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.action(action),
		.slot(slot),
		.touch_x(touch_x),
		.touch_y(touch_y),
		.stamp_ms(stamp_ms),
		.elapsed_ms(elapsed_ms),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.kind(kind),
		.button(button),
		.cursor_x(cursor_x),
		.cursor_y(cursor_y),
		.scroll_ticks(scroll_ticks)
	);

endmodule
`default_nettype wire

/* src/tgr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module tgr_checker
	import tgr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [2:0] kind,
	input wire logic button,
	input wire logic signed [13:0] scroll_ticks
);

	// A result that is held back stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Each transaction is worked on alone, so input is held off right after one is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken while busy");

	a_scroll_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_SCROLL |-> scroll_ticks != 14'sd0)
		else $error("scroll result without ticks");

	a_ticks_only_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != K_SCROLL |-> scroll_ticks == 14'sd0)
		else $error("ticks on a result that is not a scroll");

	a_left_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_MOVE || kind == K_SCROLL || kind == K_PRESS ||
			kind == K_RELEASE) |-> !button)
		else $error("right button on a move, scroll, press or release");

endmodule

bind trackpad_gesture_recognizer tgr_checker u_tgr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind(kind),
	.button(button),
	.scroll_ticks(scroll_ticks)
);
`default_nettype wire

/* tb/tb_trackpad_gesture_recognizer.sv */
`timescale 1ns / 1ps
module tb_trackpad_gesture_recognizer;
	import tgr_pkg::*;

	typedef struct {
		logic [2:0] kind;
		logic button;
		logic [11:0] cx;
		logic [11:0] cy;
		logic [13:0] ticks;
	} pointer_event_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] action;
	logic [3:0] slot;
	logic [11:0] touch_x;
	logic [11:0] touch_y;
	logic [31:0] stamp_ms;
	logic [15:0] elapsed_ms;
	logic out_valid;
	logic out_stall;
	logic [2:0] kind;
	logic button;
	logic [11:0] cursor_x;
	logic [11:0] cursor_y;
	logic signed [13:0] scroll_ticks;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pointer_event_t pending_events[$];
	int errors = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int recv_hold = 0;
	int sent_items = 0;
	logic [31:0] now_ms;

	// Shadow configuration.
	int scr_w, scr_h, tap_time, tap_rad, hold_time, scroll_step, speed;
	// Shadow gesture state.
	gesture_t gst;
	int fdx, fdy, flx, fly, sly;
	logic [31:0] fdt;
	bit sact;
	int residue, hold_el, ptr_x, ptr_y;

	trackpad_gesture_recognizer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .slot(slot), .touch_x(touch_x), .touch_y(touch_y),
		.stamp_ms(stamp_ms), .elapsed_ms(elapsed_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .button(button), .cursor_x(cursor_x), .cursor_y(cursor_y),
		.scroll_ticks(scroll_ticks),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAIL trackpad_gesture_recognizer");
		$finish;
	end

	always @(posedge clk) begin
		if (recv_hold > 0) begin
			out_stall <= 1'b1;
			recv_hold = recv_hold - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		pointer_event_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result kind=%0d", kind);
				errors++;
			end else begin
				e = pending_events.pop_front();
				if (kind !== e.kind) begin
					$error("kind expected %0d actual %0d", e.kind, kind);
					errors++;
				end
				if (button !== e.button) begin
					$error("button expected %0d actual %0d", e.button, button);
					errors++;
				end
				if (cursor_x !== e.cx) begin
					$error("cursor_x expected %0d actual %0d", e.cx, cursor_x);
					errors++;
				end
				if (cursor_y !== e.cy) begin
					$error("cursor_y expected %0d actual %0d", e.cy, cursor_y);
					errors++;
				end
				if (scroll_ticks !== e.ticks) begin
					$error("scroll_ticks expected %0d actual %0d", $signed(e.ticks),
						scroll_ticks);
					errors++;
				end
			end
		end
	end

	function automatic int dist_sq(int ax, int ay, int bx, int by);
		return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
	endfunction

	function automatic int clamp_limit(int v, int size);
		int s;
		s = (size < 1) ? 1 : ((size > 4096) ? 4096 : size);
		if (v < 0) return 0;
		if (v > ((s - 1) << 8)) return (s - 1) << 8;
		return v;
	endfunction

	function automatic void push_event(kind_t k, logic b, int t);
		pointer_event_t e;
		e.kind = k;
		e.button = b;
		e.cx = 12'(ptr_x >>> 8);
		e.cy = 12'(ptr_y >>> 8);
		e.ticks = 14'(t);
		pending_events.push_back(e);
	endfunction

	function automatic void predict_gesture(logic [1:0] a, logic [3:0] s, int x, int y,
			logic [31:0] st, int el);
		logic [31:0] dt;
		bit quick;
		int stp, acc, tk, mag;
		dt = st - fdt;
		quick = (dt <= 32'(tap_time));
		if (a == ACT_TICK) begin
			if (gst == G_TRACKING && dist_sq(fdx, fdy, flx, fly) <= tap_rad * tap_rad) begin
				hold_el = hold_el + el;
				if (hold_el > 65535) hold_el = 65535;
				if (hold_el >= hold_time) begin
					gst = G_DRAGGING;
					hold_el = 0;
					push_event(K_PRESS, 1'b0, 0);
				end
			end else begin
				hold_el = 0;
			end
		end else if (s == 4'd0) begin
			if (a == ACT_DOWN) begin
				fdx = x; flx = x; fdy = y; fly = y;
				fdt = st;
				residue = 0;
				if (gst == G_IDLE) gst = G_TRACKING;
			end else if (a == ACT_MOVE) begin
				if (gst == G_TRACKING && dist_sq(fdx, fdy, x, y) > tap_rad * tap_rad)
					gst = G_MOVING;
				if (gst == G_MOVING || gst == G_DRAGGING) begin
					ptr_x = clamp_limit(ptr_x + (x - flx) * speed, scr_w);
					ptr_y = clamp_limit(ptr_y + (y - fly) * speed, scr_h);
					push_event(K_MOVE, 1'b0, 0);
				end
				flx = x;
				fly = y;
			end else begin
				if (gst == G_TRACKING && quick && dist_sq(fdx, fdy, x, y) <= tap_rad * tap_rad)
					push_event(K_CLICK, 1'b0, 0);
				else if (gst == G_DRAGGING)
					push_event(K_RELEASE, 1'b0, 0);
				if (!sact) gst = G_IDLE;
			end
		end else if (s == 4'd1) begin
			if (a == ACT_DOWN) begin
				sact = 1'b1;
				sly = y;
				residue = 0;
				gst = G_TWO;
			end else if (a == ACT_MOVE) begin
				if (gst == G_TWO) begin
					stp = (scroll_step != 0) ? scroll_step : 1;
					acc = residue + (y - sly);
					tk = acc / stp;
					residue = acc - tk * stp;
					if (tk != 0) push_event(K_SCROLL, 1'b0, -tk);
				end
				sly = y;
			end else begin
				mag = (residue < 0) ? -residue : residue;
				if (gst == G_TWO && quick && mag < tap_rad)
					push_event(K_CLICK, 1'b1, 0);
				sact = 1'b0;
				gst = G_TRACKING;
			end
		end
	endfunction

	function automatic int clip_coord(int v);
		return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
	endfunction

	task automatic send_touch(action_t a, logic [3:0] s, int x, int y, int el);
		in_valid <= 1'b1;
		action <= a;
		slot <= s;
		touch_x <= 12'(x);
		touch_y <= 12'(y);
		stamp_ms <= now_ms;
		elapsed_ms <= 16'(el);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_gesture(a, s, x, y, now_ms, el);
		sent_items++;
		if ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_SCREEN_W: scr_w = value & 16'h1FFF;
			CFG_SCREEN_H: scr_h = value & 16'h1FFF;
			CFG_TAP_TIME: tap_time = value & 16'hFFFF;
			CFG_TAP_RADIUS: tap_rad = value & 8'hFF;
			CFG_HOLD_TIME: hold_time = value & 16'hFFFF;
			CFG_SCROLL_STEP: scroll_step = value & 8'hFF;
			CFG_SPEED: speed = value & 10'h3FF;
			default: ;
		endcase
	endtask

	task automatic write_all(int w, int h, int tt, int rad, int ht, int stp, int spd);
		write_register(CFG_SCREEN_W, w);
		write_register(CFG_SCREEN_H, h);
		write_register(CFG_TAP_TIME, tt);
		write_register(CFG_TAP_RADIUS, rad);
		write_register(CFG_HOLD_TIME, ht);
		write_register(CFG_SCROLL_STEP, stp);
		write_register(CFG_SPEED, spd);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_session();
		int x, y, steps, k, sy, n;
		now_ms = now_ms + $urandom_range(0, 60);
		x = $urandom_range(0, 4095);
		y = $urandom_range(0, 4095);
		send_touch(ACT_DOWN, 4'd0, x, y, 0);
		steps = $urandom_range(1, 8);
		repeat (steps) begin
			now_ms = now_ms + $urandom_range(0, 40);
			k = $urandom_range(0, 9);
			if (k < 3) begin
				send_touch(ACT_TICK, 4'($urandom_range(0, 15)), x, y,
					($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300));
			end else if (k < 5) begin
				x = clip_coord(x + $urandom_range(0, 2 * tap_rad + 2) - tap_rad - 1);
				y = clip_coord(y + $urandom_range(0, 2 * tap_rad + 2) - tap_rad - 1);
				send_touch(ACT_MOVE, 4'd0, x, y, 0);
			end else if (k < 7) begin
				x = $urandom_range(0, 4095);
				y = $urandom_range(0, 4095);
				send_touch(ACT_MOVE, 4'd0, x, y, 0);
			end else if (k < 9) begin
				sy = $urandom_range(0, 4095);
				send_touch(ACT_DOWN, 4'd1, $urandom_range(0, 4095), sy, 0);
				n = $urandom_range(0, 4);
				repeat (n) begin
					now_ms = now_ms + $urandom_range(0, 30);
					sy = ($urandom_range(3) == 0) ? $urandom_range(0, 4095)
						: clip_coord(sy + $urandom_range(0, 120) - 60);
					send_touch(ACT_MOVE, 4'd1, $urandom_range(0, 4095), sy, 0);
				end
				now_ms = now_ms + $urandom_range(0, 250);
				send_touch(ACT_UP, 4'd1, $urandom_range(0, 4095), sy, 0);
			end else begin
				send_touch(action_t'($urandom_range(0, 3)), 4'($urandom_range(0, 9)),
					$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535));
			end
		end
		now_ms = now_ms + (($urandom_range(1) == 0) ? $urandom_range(0, 200)
			: $urandom_range(0, 1000));
		send_touch(ACT_UP, 4'd0, x, y, 0);
	endtask

	task automatic run_sessions(int items);
		int start;
		start = sent_items;
		while (sent_items - start < items) begin
			random_session();
		end
		drain_results();
	endtask

	task automatic test_directed();
		now_ms = 32'hFFFF_FFF0;
		send_touch(ACT_DOWN, 4'd0, 100, 100, 0);
		now_ms = now_ms + 20;
		send_touch(ACT_UP, 4'd0, 102, 101, 0);
		send_touch(ACT_DOWN, 4'd0, 500, 500, 0);
		send_touch(ACT_TICK, 4'd7, 0, 0, 65535);
		send_touch(ACT_MOVE, 4'd0, 0, 0, 0);
		send_touch(ACT_MOVE, 4'd0, 0, 0, 0);
		send_touch(ACT_MOVE, 4'd0, 4095, 4095, 0);
		send_touch(ACT_UP, 4'd0, 4095, 4095, 0);
		send_touch(ACT_DOWN, 4'd0, 200, 200, 0);
		send_touch(ACT_DOWN, 4'd1, 300, 1000, 0);
		send_touch(ACT_MOVE, 4'd1, 300, 0, 0);
		send_touch(ACT_MOVE, 4'd1, 300, 4095, 0);
		send_touch(ACT_UP, 4'd1, 300, 4095, 0);
		send_touch(ACT_DOWN, 4'd1, 300, 300, 0);
		send_touch(ACT_UP, 4'd1, 300, 300, 0);
		send_touch(ACT_UP, 4'd0, 200, 200, 0);
		send_touch(ACT_DOWN, 4'd9, 1, 2, 0);
		send_touch(ACT_MOVE, 4'd15, 4095, 4095, 0);
		send_touch(ACT_UP, 4'd2, 3, 4, 0);
		send_touch(ACT_DOWN, 4'd0, 1000, 1000, 0);
		send_touch(ACT_MOVE, 4'd0, 3000, 20, 0);
		now_ms = now_ms + 5000;
		send_touch(ACT_UP, 4'd0, 3000, 20, 0);
		drain_results();
	endtask

	task automatic test_config_extremes();
		write_all(0, 8191, 0, 0, 1, 0, 1023);
		run_sessions(120);
		write_all(4096, 1, 65535, 255, 65535, 255, 1);
		run_sessions(120);
		write_all(1, 4096, 65535, 0, 1, 1, 1023);
		run_sessions(100);
	endtask

	task automatic test_random_idling(int sp, int rp);
		send_pct = sp;
		recv_pct = rp;
		write_all($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 400),
			$urandom_range(0, 40), $urandom_range(1, 800), $urandom_range(1, 255),
			$urandom_range(1, 1023));
		run_sessions(300);
	endtask

	task automatic test_backpressure();
		int i;
		send_pct = 0;
		recv_pct = 0;
		write_all(4096, 4096, 180, 0, 400, 1, 307);
		send_touch(ACT_DOWN, 4'd0, 2000, 2000, 0);
		send_touch(ACT_MOVE, 4'd0, 2100, 2100, 0);
		recv_hold = 300;
		for (i = 0; i < 30; i++)
			send_touch(ACT_MOVE, 4'd0, $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
		send_touch(ACT_DOWN, 4'd1, 0, 0, 0);
		for (i = 0; i < 10; i++)
			send_touch(ACT_MOVE, 4'd1, 0, $urandom_range(0, 4095), 0);
		send_touch(ACT_UP, 4'd1, 0, 0, 0);
		send_touch(ACT_UP, 4'd0, 0, 0, 0);
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		slot = '0;
		touch_x = '0;
		touch_y = '0;
		stamp_ms = '0;
		elapsed_ms = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		scr_w = 1920; scr_h = 1080; tap_time = 180; tap_rad = 10;
		hold_time = 400; scroll_step = 40; speed = 307;
		gst = G_IDLE;
		fdx = 0; fdy = 0; flx = 0; fly = 0; sly = 0; fdt = '0;
		sact = 1'b0;
		residue = 0; hold_el = 0; ptr_x = 0; ptr_y = 0;
		now_ms = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		now_ms = $urandom();
		run_sessions(100);
		test_config_extremes();
		test_random_idling(14, 56);
		test_random_idling(56, 14);
		test_random_idling(0, 0);
		test_backpressure();
		if (errors == 0) begin
			$display("PASS trackpad_gesture_recognizer");
		end else begin
			$display("FAIL trackpad_gesture_recognizer");
		end
		$finish;
	end

endmodule
